// ===== rtl/core/sis_pkg.sv =====
package sis_pkg;

	// Field widths of one entry
	localparam int unsigned PAYLOAD_BITS = 16;
	localparam int unsigned KEY_BITS     = 32;

	// Input transaction
	typedef struct packed {
		logic [PAYLOAD_BITS-1:0]    payload;
		logic signed [KEY_BITS-1:0] key;
		logic                       last_in;
	} in_t;

	// Output transaction
	typedef struct packed {
		logic [PAYLOAD_BITS-1:0]    sorted_payload;
		logic signed [KEY_BITS-1:0] sorted_key;
		logic                       last_out;
		logic                       overflow;
	} out_t;

	// Contents of one chain cell
	typedef struct packed {
		logic                       valid;
		logic [PAYLOAD_BITS-1:0]    payload;
		logic signed [KEY_BITS-1:0] key;
	} entry_t;

	// Chain-wide control broadcast to every cell
	typedef struct packed {
		logic insert;   // place the incoming entry
		logic shift;    // drain: every cell takes its right neighbor
	} ctrl_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

endpackage

// ===== rtl/core/stable_insertion_sorter_top.sv =====
// Stable ascending insertion sorter.
// Input channel item_valid/item_ready/item carries one entry (payload, signed
// key, last_in). Each accepted entry is placed in a chain of CAPACITY cells
// after any stored entries with an equal key, so entries are taken at one
// per cycle while a list is collected.
// After the entry marked last_in is accepted, item_ready drops and the chain
// drains through result_valid/result_ready/result: one transaction per cycle
// while result_ready is high, ascending by key, starting once state_q is ST_DRAIN.
// The final transaction of the list carries last_out; overflow is set on every
// transaction of a list that had entries arriving while all cells were full
// (those entries are discarded, a discarded last_in still closes the list).
// A list is therefore collected first and then drained one stored entry at
// a time through the single output register fed from cell 0.
// With a result held and result_ready low, the output holds and the chain waits;
// input is taken again once the final result has entered the output register.
// Reset (arst_n low) empties the chain and drops any pending result.
module stable_insertion_sorter_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  sis_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_ready,
	output sis_pkg::out_t result
);

	sis_pkg::state_t state_q;
	sis_pkg::state_t state_d;
	sis_pkg::entry_t chain [CAPACITY];
	logic            gt [CAPACITY];
	sis_pkg::entry_t new_entry;
	sis_pkg::ctrl_t  ctrl;
	logic            accept;
	logic            full;
	logic            load;
	logic            final_load;
	logic            dropped_q;
	logic            result_valid_q;
	sis_pkg::out_t   result_q;

	// Input handshake
	assign item_ready = (state_q == sis_pkg::ST_COLLECT);
	assign accept     = item_valid && item_ready;
	assign full       = chain[CAPACITY-1].valid;

	assign new_entry.valid   = 1'b1;
	assign new_entry.payload = item.payload;
	assign new_entry.key     = item.key;

	// Drain into the output register whenever it is free
	assign load       = (state_q == sis_pkg::ST_DRAIN) && (!result_valid_q || result_ready);
	assign final_load = load && !chain[1].valid;

	assign ctrl.insert = accept && !full;
	assign ctrl.shift  = load;

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sis_pkg::entry_t left_e;
		sis_pkg::entry_t right_e;
		logic            left_gt;

		// head has no neighbor: its left counts as occupied so an empty chain loads cell 0
		if (i == 0) begin : g_head
			assign left_e  = '{valid: 1'b1, default: '0};
			assign left_gt = 1'b0;
		end else begin : g_body
			assign left_e  = chain[i-1];
			assign left_gt = gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = chain[i+1];
		end

		sis_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_entry (new_entry),
			.left      (left_e),
			.left_gt   (left_gt),
			.right     (right_e),
			.cur       (chain[i]),
			.gt        (gt[i])
		);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sis_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sis_pkg::ST_COLLECT: begin
				if (accept && item.last_in) begin
					state_d = sis_pkg::ST_DRAIN;
				end
			end
			sis_pkg::ST_DRAIN: begin
				if (final_load) begin
					state_d = sis_pkg::ST_COLLECT;
				end
			end
			default: state_d = sis_pkg::ST_COLLECT;
		endcase
	end

	// Overflow flag for the current list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (final_load) begin
			dropped_q <= 1'b0;
		end else if (accept && full) begin
			dropped_q <= 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q.sorted_payload <= chain[0].payload;
			result_q.sorted_key     <= chain[0].key;
			result_q.last_out       <= !chain[1].valid;
			result_q.overflow       <= dropped_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Draining always has a head entry to send
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sis_pkg::ST_DRAIN) |-> chain[0].valid)
		else $error("drain with empty head cell");

	// Occupied cells form a prefix of the chain
	for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_prefix_chk
		a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			chain[j+1].valid |-> chain[j].valid)
			else $error("hole in cell chain");
	end

	// Chain stays ordered at the head while draining
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(load && chain[1].valid) |-> ($signed(chain[1].key) >= $signed(chain[0].key)))
		else $error("chain out of order");

	// Overflow is raised only by an entry arriving at a full chain
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> $past(accept && full))
		else $error("overflow set without a dropped entry");
`endif

endmodule

// ===== rtl/core/sis_cell.sv =====
module sis_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  sis_pkg::ctrl_t ctrl,
	input  sis_pkg::entry_t new_entry,
	input  sis_pkg::entry_t left,
	input  logic           left_gt,
	input  sis_pkg::entry_t right,
	output sis_pkg::entry_t cur,
	output logic           gt
);

	logic                                valid_q;
	logic [sis_pkg::PAYLOAD_BITS-1:0]    payload_q;
	logic signed [sis_pkg::KEY_BITS-1:0] key_q;
	sis_pkg::entry_t                     cell_d;
	logic                                take_new;

	assign cur = '{valid: valid_q, payload: payload_q, key: key_q};

	// Stored entry is strictly greater than the incoming one: it moves right
	assign gt = cur.valid && ($signed(cur.key) > $signed(new_entry.key));

	// New entry lands in the first cell that is greater, or in the first empty cell
	assign take_new = (gt || (!cur.valid && left.valid)) && !left_gt;

	// Next cell contents
	always_comb begin
		cell_d = cur;
		if (ctrl.shift) begin
			cell_d = right;
		end else if (ctrl.insert) begin
			if (left_gt) begin
				cell_d = left;
			end else if (take_new) begin
				cell_d       = new_entry;
				cell_d.valid = 1'b1;
			end
		end
	end

	// Occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cell_d.valid;
		end
	end

	// Data, no reset
	always_ff @(posedge clk) begin
		payload_q <= cell_d.payload;
		key_q     <= cell_d.key;
	end

endmodule
